@@ hdl/rmxq_pkg.sv @@
`default_nettype none
package rmxq_pkg;

    localparam int DEPTH      = 4096;
    localparam int VALUE_BITS = 19;
    localparam int LANES      = 16;
    localparam int ROWS       = DEPTH / LANES;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int LANE_BITS  = $clog2(LANES);
    localparam int ROW_BITS   = $clog2(ROWS);
    localparam int COUNT_BITS = 13;
    localparam int GROUPS     = LANES / 4;

    localparam int DATA_BITS  = 32;
    localparam int PADDR_BITS = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(DEPTH);

    // register index taken from the word address bit
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic           operation;
        logic [11:0]    write_index;
        logic [18:0]    write_value;
        logic [18:0]    query_key;
        logic [11:0]    range_first;
        logic [11:0]    range_last;
    } item_t;

    typedef struct packed {
        logic [18:0]    best_xor;
        logic           range_error;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic write_en;
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic range_bad;
        logic last_row;
        logic pipe_busy;
    } dp_status_t;

    function automatic value_t max2(input value_t a, input value_t b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

@@ hdl/rmxq_cfg.sv @@
`default_nettype none
module rmxq_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rmxq_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [rmxq_pkg::DATA_BITS-1:0]     pwdata,
    output logic      [rmxq_pkg::DATA_BITS-1:0]     prdata,
    output logic                                    pready,
    output logic      [rmxq_pkg::COUNT_BITS-1:0]    element_count
);

    logic [rmxq_pkg::COUNT_BITS-1:0] count_reg;
    logic [rmxq_pkg::COUNT_BITS-1:0] count_next;
    logic                            hit;

    assign hit = (paddr[2] == rmxq_pkg::REG_ELEMENT_COUNT);

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && hit)
        begin
            count_next = pwdata[rmxq_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= rmxq_pkg::COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata = hit ? rmxq_pkg::DATA_BITS'(count_reg) : '0;
    assign pready = 1'b1;
    assign element_count = count_reg;

endmodule
`default_nettype wire

@@ hdl/rmxq_ctrl.sv @@
`default_nettype none
module rmxq_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   operation,
    input  wire rmxq_pkg::dp_status_t   status,
    output rmxq_pkg::ctrl_cmd_t         cmd,
    output logic                        busy,
    output logic                        done
);

    rmxq_pkg::state_t state_reg;
    rmxq_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmxq_pkg::ST_IDLE:
            begin
                if (start && (operation == rmxq_pkg::OP_QUERY))
                begin
                    state_next = status.range_bad ? rmxq_pkg::ST_RESULT : rmxq_pkg::ST_SCAN;
                end
            end
            rmxq_pkg::ST_SCAN:
            begin
                if (status.last_row)
                begin
                    state_next = rmxq_pkg::ST_DRAIN;
                end
            end
            rmxq_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = rmxq_pkg::ST_RESULT;
                end
            end
            rmxq_pkg::ST_RESULT:
            begin
                state_next = rmxq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rmxq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            rmxq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.write_en = (operation == rmxq_pkg::OP_WRITE);
                    cmd.load     = (operation == rmxq_pkg::OP_QUERY);
                end
            end
            rmxq_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            rmxq_pkg::ST_DRAIN:
            begin
            end
            rmxq_pkg::ST_RESULT:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmxq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/rmxq_dp.sv @@
`default_nettype none
module rmxq_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rmxq_pkg::item_t                    item,
    input  wire logic [rmxq_pkg::COUNT_BITS-1:0]    element_count,
    input  wire rmxq_pkg::ctrl_cmd_t                cmd,
    output rmxq_pkg::dp_status_t                    status,
    output rmxq_pkg::result_t                       result
);

    typedef rmxq_pkg::value_t row_word_t [rmxq_pkg::LANES];

    rmxq_pkg::value_t mem [rmxq_pkg::ROWS][rmxq_pkg::LANES];

    rmxq_pkg::value_t                   key_reg;
    logic [rmxq_pkg::ADDR_BITS-1:0]     first_reg;
    logic [rmxq_pkg::ADDR_BITS-1:0]     last_reg;
    logic [rmxq_pkg::ROW_BITS-1:0]      row_reg;
    logic                               err_reg;
    row_word_t                          rd_data_reg;
    logic [rmxq_pkg::LANES-1:0]         mask_reg;
    logic                               s1_valid_reg;
    rmxq_pkg::value_t                   quad_reg [rmxq_pkg::GROUPS];
    rmxq_pkg::value_t                   quad_next [rmxq_pkg::GROUPS];
    logic                               s2_valid_reg;
    rmxq_pkg::value_t                   best_reg;
    rmxq_pkg::value_t                   best_next;

    logic [rmxq_pkg::COUNT_BITS-1:0]    limit;
    logic [rmxq_pkg::LANES-1:0]         mask_next;
    logic [rmxq_pkg::ROW_BITS-1:0]      first_row;
    logic [rmxq_pkg::ROW_BITS-1:0]      last_row;
    logic [rmxq_pkg::ROW_BITS-1:0]      wr_row;
    logic [rmxq_pkg::LANE_BITS-1:0]     wr_lane;

    assign limit = (element_count > rmxq_pkg::COUNT_LIMIT) ? rmxq_pkg::COUNT_LIMIT
                                                           : element_count;

    assign status.range_bad = (item.range_first > item.range_last) ||
        ({1'b0, item.range_last} >= limit);
    assign first_row        = first_reg[rmxq_pkg::ADDR_BITS-1:rmxq_pkg::LANE_BITS];
    assign last_row         = last_reg[rmxq_pkg::ADDR_BITS-1:rmxq_pkg::LANE_BITS];
    assign status.last_row  = (row_reg == last_row);
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;

    assign wr_row  = item.write_index[rmxq_pkg::ADDR_BITS-1:rmxq_pkg::LANE_BITS];
    assign wr_lane = item.write_index[rmxq_pkg::LANE_BITS-1:0];

    // lanes outside the range on the end rows read as zero
    always_comb
    begin
        for (int l = 0; l < rmxq_pkg::LANES; l++)
        begin
            mask_next[l] = 1'b1;
            if ((row_reg == first_row) &&
                (rmxq_pkg::LANE_BITS'(l) < first_reg[rmxq_pkg::LANE_BITS-1:0]))
            begin
                mask_next[l] = 1'b0;
            end
            if ((row_reg == last_row) &&
                (rmxq_pkg::LANE_BITS'(l) > last_reg[rmxq_pkg::LANE_BITS-1:0]))
            begin
                mask_next[l] = 1'b0;
            end
        end
    end

    always_comb
    begin
        rmxq_pkg::value_t x [4];
        for (int g = 0; g < rmxq_pkg::GROUPS; g++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                x[k] = mask_reg[4*g+k] ? (key_reg ^ rd_data_reg[4*g+k]) : '0;
            end
            quad_next[g] = rmxq_pkg::max2(rmxq_pkg::max2(x[0], x[1]),
                                          rmxq_pkg::max2(x[2], x[3]));
        end
    end

    always_comb
    begin
        best_next = rmxq_pkg::max2(best_reg,
            rmxq_pkg::max2(rmxq_pkg::max2(quad_reg[0], quad_reg[1]),
                           rmxq_pkg::max2(quad_reg[2], quad_reg[3])));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_en)
        begin
            mem[wr_row][wr_lane] <= item.write_value;
        end
        if (cmd.step)
        begin
            rd_data_reg <= mem[row_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.step;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= item.query_key;
            first_reg <= item.range_first;
            last_reg  <= item.range_last;
            row_reg   <= item.range_first[rmxq_pkg::ADDR_BITS-1:rmxq_pkg::LANE_BITS];
            err_reg   <= status.range_bad;
            best_reg  <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                row_reg  <= row_reg + rmxq_pkg::ROW_BITS'(1);
                mask_reg <= mask_next;
            end
            if (s2_valid_reg)
            begin
                best_reg <= best_next;
            end
        end
        if (s1_valid_reg)
        begin
            quad_reg <= quad_next;
        end
    end

    assign result.best_xor    = best_reg;
    assign result.range_error = err_reg;

endmodule
`default_nettype wire

@@ hdl/range_max_xor_query.sv @@
// Range maximum-XOR query engine.
//
// Command channel: drive item and raise start; the item is taken at a clock
// edge where start is high and busy is low. A write beat (operation 0) stores
// write_value at write_index at that edge and busy stays low, so another
// beat may follow at once. A query beat (operation 1) returns the largest
// key XOR element over range_first..range_last on result, marked by done for
// exactly one cycle. The receiver cannot stall; result is valid only then.
// The store is read sixteen elements per cycle: a query scans each row of
// sixteen that its range spans, then the max tree reduces each row to group
// maxima and folds them into the running best; once the tree is empty, done
// is raised. A query with an empty range or one past element_count gives
// range_error with best_xor zero, with done in the cycle after acceptance.
// A new query is not taken while one is in flight: busy stays high through
// the result cycle and the next beat is taken once the engine is idle.
// element_count is set over the APB port at byte address 0; the user must
// write it only while idle, and the block itself does not enforce this.
// Reset returns the controller to idle and element_count to 1; the element
// store is not cleared and must be written before it is queried.
`default_nettype none
module range_max_xor_query (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire rmxq_pkg::item_t                    item,
    output logic                                    done,
    output rmxq_pkg::result_t                       result,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rmxq_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [rmxq_pkg::DATA_BITS-1:0]     pwdata,
    output logic      [rmxq_pkg::DATA_BITS-1:0]     prdata,
    output logic                                    pready
);

    logic [rmxq_pkg::COUNT_BITS-1:0] element_count;
    rmxq_pkg::ctrl_cmd_t             cmd;
    rmxq_pkg::dp_status_t            status;

    rmxq_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .element_count (element_count)
    );

    rmxq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    rmxq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .element_count (element_count),
        .cmd           (cmd),
        .status        (status),
        .result        (result)
    );

endmodule
`default_nettype wire

@@ hdl/rmxq_checker.sv @@
`default_nettype none
module rmxq_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire rmxq_pkg::item_t    item,
    input  wire logic               done,
    input  wire rmxq_pkg::result_t  result
);

    logic accept;

    assign accept = start && !busy;

    // a result only appears while the engine is busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation == rmxq_pkg::OP_WRITE)) |=> !busy && !done)
        else $error("write beat stalled the engine or made a result");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation == rmxq_pkg::OP_QUERY)) |=> busy)
        else $error("query beat did not hold busy");

    a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation == rmxq_pkg::OP_QUERY) &&
         (item.range_first > item.range_last))
        |=> done && result.range_error && (result.best_xor == '0))
        else $error("empty range not flagged at once");

endmodule

bind range_max_xor_query rmxq_checker u_checker (.*);
`default_nettype wire
